// ----- hdl/ces_pkg.sv -----
package ces_pkg;

	// Operation kind, carried on the input tuser.
	typedef enum logic [2:0] {
		KIND_SKIP,
		KIND_ADD,
		KIND_SUB,
		KIND_MUL,
		KIND_DIV,
		KIND_BR,
		KIND_BLT,
		KIND_BZ
	} kind_t;

	// Control mode, carried in the lowest bits of the input tdata.
	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_IMM,
		MODE_REL,
		MODE_HALT
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EXEC,
		ST_ITER,
		ST_SIGN,
		ST_DONE
	} state_t;

	localparam int KIND_W     = 3;
	localparam int IDX_W      = 4;
	localparam int FIELD_W    = 32;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 72;

endpackage

// ----- hdl/ces_ram.sv -----
module ces_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/cpu_execute_stage.sv -----
// Execute stage of a small processor, holding its own register file.
// Input channel (s_axis_*): one item is one decoded instruction. The operation
// kind travels on tuser; the mode, register numbers, immediate and PC travel
// on tdata. Output channel (m_axis_*): one item per instruction, giving the
// register write, the PC write, the halt flag and the divide-by-zero status.
// The register file sits in two copies of a synchronous RAM (one read port
// each); a valid bit per register makes a never-written register read zero.
// Add, sub, branches and skip pass from acceptance to the loading of the
// result item through operand read and latch, execute and commit. Multiply
// and divide (but for a divide by zero) also run through one shared
// shift-and-add / restoring divide unit that retires one bit per cycle,
// then a result step that sets the quotient's sign, before commit. One item
// is in flight at a time; the next item can be accepted in the cycle after
// the previous result is loaded.
// The result register decouples the sides: a finished item may wait there
// while the next instruction is accepted and executed. If the receiver still
// holds off when that next instruction finishes, the block waits in its
// commit state and writes neither the register file nor the output.
// Reset clears all valid bits (the whole file reads zero) and the control
// state at once; no clearing pass is needed.
module cpu_execute_stage #(
	parameter int NUM_REGS  = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Instruction items.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata, lowest bit up: control_mode[1:0], dst_index[5:2],
	// src1_index[9:6], src2_index[13:10], immediate[45:14],
	// current_pc[77:46], zero fill[79:78].
	input  logic [ces_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// tuser: kind[2:0].
	input  logic [ces_pkg::KIND_W-1:0]       s_axis_tuser,
	// Result items.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata, lowest bit up: reg_write[0], write_index[4:1],
	// write_data[36:5], pc_write[37], new_pc[69:38], halt[70], status[71].
	output logic [ces_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	localparam int RIDX_W = $clog2(NUM_REGS);
	localparam int CNT_W  = $clog2(WORD_BITS);

	// Register numbers are taken modulo the file size; the index field is
	// only four bits, so this is a small constant table.
	function automatic logic [RIDX_W-1:0] reg_sel(input logic [ces_pkg::IDX_W-1:0] idx);
		logic [RIDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (idx == ces_pkg::IDX_W'(i)) begin
				r = RIDX_W'(i % NUM_REGS);
			end
		end
		return r;
	endfunction

	ces_pkg::state_t state_q, state_d;

	// Item fields held for the duration of the instruction.
	ces_pkg::kind_t     kind_q;
	ces_pkg::mode_t     mode_q;
	logic [RIDX_W-1:0]  dst_q;
	logic [WORD_BITS-1:0] imm_q, pc_q;
	logic               vld1_q, vld2_q;

	// Operands and execute results.
	logic [WORD_BITS-1:0] a_q, b_q, opnd_q;
	logic [WORD_BITS-1:0] res_q, npc_q;
	logic               wr_q, pw_q, st_q, neg_q;

	// Execute decode.
	logic [WORD_BITS-1:0] br_target, exe_res, exe_npc, exe_x, exe_y;
	logic                 exe_wr, exe_pw, exe_st;

	// Shared multiply / divide unit.
	logic [WORD_BITS-1:0] acc_q, x_q, y_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] acc_d, x_d, y_d;
	logic [WORD_BITS:0]   rem_sh, rem_diff;
	logic                 rem_ge;

	// Output register.
	logic                 out_vld_q, out_rw_q, out_pw_q, out_halt_q, out_st_q;
	logic [ces_pkg::IDX_W-1:0]   out_wi_q;
	logic [ces_pkg::FIELD_W-1:0] out_wd_q, out_npc_q;

	// Register file.
	logic [NUM_REGS-1:0]  valid_q;
	logic [WORD_BITS-1:0] rd1, rd2;
	logic                 accept, out_free, out_load, ram_we;

	logic [ces_pkg::IDX_W-1:0] src1_idx, src2_idx, dst_idx;
	logic [RIDX_W-1:0]         src1_sel, src2_sel;

	assign src1_idx = s_axis_tdata[9:6];
	assign src2_idx = s_axis_tdata[13:10];
	assign dst_idx  = s_axis_tdata[5:2];
	assign src1_sel = reg_sel(src1_idx);
	assign src2_sel = reg_sel(src2_idx);

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;

	ces_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_REGS)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dst_q),
		.wdata (res_q),
		.re    (accept),
		.raddr (src1_sel),
		.rdata (rd1)
	);

	ces_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_REGS)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (dst_q),
		.wdata (res_q),
		.re    (accept),
		.raddr (src2_sel),
		.rdata (rd2)
	);

	// One step of the shared unit: a multiply adds the shifted multiplicand
	// under the low multiplier bit; a divide shifts in the next dividend bit
	// and subtracts the divisor when it fits.
	always_comb begin
		rem_sh   = {acc_q, x_q[WORD_BITS-1]};
		rem_diff = rem_sh - {1'b0, y_q};
		rem_ge   = !rem_diff[WORD_BITS];
		if (kind_q == ces_pkg::KIND_DIV) begin
			acc_d = rem_ge ? rem_diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
			x_d   = {x_q[WORD_BITS-2:0], rem_ge};
			y_d   = y_q;
		end else begin
			acc_d = acc_q + (y_q[0] ? x_q : '0);
			x_d   = {x_q[WORD_BITS-2:0], 1'b0};
			y_d   = {1'b0, y_q[WORD_BITS-1:1]};
		end
	end

	// Execute decode for the instruction in the operand registers. Branch
	// targets are absolute unless the mode asks for a PC-relative target.
	always_comb begin
		br_target = (mode_q == ces_pkg::MODE_REL) ? pc_q + imm_q - WORD_BITS'(1) : imm_q;
		exe_wr    = 1'b0;
		exe_pw    = 1'b0;
		exe_st    = 1'b0;
		exe_npc   = pc_q;
		exe_res   = '0;
		exe_x     = a_q;
		exe_y     = opnd_q;
		case (kind_q)
			ces_pkg::KIND_ADD: begin
				exe_res = a_q + opnd_q;
				exe_wr  = 1'b1;
			end
			ces_pkg::KIND_SUB: begin
				exe_res = a_q - opnd_q;
				exe_wr  = 1'b1;
			end
			ces_pkg::KIND_MUL: exe_wr = 1'b1;
			ces_pkg::KIND_DIV: begin
				exe_x  = a_q[WORD_BITS-1] ? -a_q : a_q;
				exe_y  = opnd_q[WORD_BITS-1] ? -opnd_q : opnd_q;
				exe_wr = (opnd_q != '0);
				exe_st = (opnd_q == '0);
			end
			ces_pkg::KIND_BR: begin
				exe_pw  = 1'b1;
				exe_npc = br_target;
			end
			ces_pkg::KIND_BLT: begin
				exe_pw = 1'b1;
				if ($signed(a_q) < $signed(b_q)) begin
					exe_npc = br_target;
				end
			end
			ces_pkg::KIND_BZ: begin
				exe_pw = 1'b1;
				if (a_q == '0) begin
					exe_npc = br_target;
				end
			end
			default: exe_wr = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ces_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ces_pkg::ST_LOAD;
				end
			end
			ces_pkg::ST_LOAD: state_d = ces_pkg::ST_EXEC;
			ces_pkg::ST_EXEC: begin
				if (kind_q == ces_pkg::KIND_MUL ||
				    (kind_q == ces_pkg::KIND_DIV && opnd_q != '0)) begin
					state_d = ces_pkg::ST_ITER;
				end else begin
					state_d = ces_pkg::ST_DONE;
				end
			end
			ces_pkg::ST_ITER: begin
				if (cnt_q == '0) begin
					state_d = ces_pkg::ST_SIGN;
				end
			end
			ces_pkg::ST_SIGN: state_d = ces_pkg::ST_DONE;
			ces_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ces_pkg::ST_IDLE;
				end
			end
			default: state_d = ces_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ces_pkg::ST_IDLE: s_axis_tready = 1'b1;
			ces_pkg::ST_DONE: out_load = out_free;
			ces_pkg::ST_LOAD, ces_pkg::ST_EXEC, ces_pkg::ST_ITER,
			ces_pkg::ST_SIGN: out_load = 1'b0;
			default: s_axis_tready = 1'b0;
		endcase
	end

	assign ram_we = out_load && wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ces_pkg::ST_IDLE;
			valid_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[dst_q] <= 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= ces_pkg::kind_t'(s_axis_tuser);
			mode_q <= ces_pkg::mode_t'(s_axis_tdata[1:0]);
			dst_q  <= reg_sel(dst_idx);
			imm_q  <= WORD_BITS'($signed(s_axis_tdata[45:14]));
			pc_q   <= WORD_BITS'($signed(s_axis_tdata[77:46]));
			vld1_q <= valid_q[src1_sel];
			vld2_q <= valid_q[src2_sel];
		end

		if (state_q == ces_pkg::ST_LOAD) begin
			a_q    <= vld1_q ? rd1 : '0;
			b_q    <= vld2_q ? rd2 : '0;
			opnd_q <= (mode_q == ces_pkg::MODE_IMM) ? imm_q : (vld2_q ? rd2 : '0);
		end

		if (state_q == ces_pkg::ST_EXEC) begin
			wr_q  <= exe_wr;
			pw_q  <= exe_pw;
			st_q  <= exe_st;
			npc_q <= exe_npc;
			res_q <= exe_res;
			neg_q <= a_q[WORD_BITS-1] ^ opnd_q[WORD_BITS-1];
			acc_q <= '0;
			cnt_q <= CNT_W'(WORD_BITS - 1);
			x_q   <= exe_x;
			y_q   <= exe_y;
		end

		if (state_q == ces_pkg::ST_ITER) begin
			acc_q <= acc_d;
			x_q   <= x_d;
			y_q   <= y_d;
			cnt_q <= cnt_q - CNT_W'(1);
		end

		// The quotient of magnitudes takes the sign of the operands; the
		// most negative value divided by minus one wraps back to itself.
		if (state_q == ces_pkg::ST_SIGN) begin
			if (kind_q == ces_pkg::KIND_DIV) begin
				res_q <= neg_q ? -x_q : x_q;
			end else begin
				res_q <= acc_q;
			end
		end

		if (out_load) begin
			out_rw_q   <= wr_q;
			out_wi_q   <= wr_q ? ces_pkg::IDX_W'(dst_q) : '0;
			out_wd_q   <= wr_q ? ces_pkg::FIELD_W'(res_q) : '0;
			out_pw_q   <= pw_q;
			out_npc_q  <= ces_pkg::FIELD_W'(npc_q);
			out_halt_q <= (mode_q == ces_pkg::MODE_HALT);
			out_st_q   <= st_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_st_q, out_halt_q, out_npc_q, out_pw_q,
	                        out_wd_q, out_wi_q, out_rw_q};

	// Only multiply and divide may occupy the iterative unit.
	a_iter_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ces_pkg::ST_ITER) |->
		(kind_q == ces_pkg::KIND_MUL || kind_q == ces_pkg::KIND_DIV))
		else $error("iterative unit busy with a kind that does not use it");

	// A register write marks its entry valid for later reads.
	a_valid_set: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(dst_q)])
		else $error("written register not marked valid");

	// A divide by zero never reports a register write.
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_st_q) |-> !out_rw_q)
		else $error("divide by zero reported with a register write");

	// One instruction at a time: no acceptance right after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second item accepted while one is in flight");

endmodule
